[hw/rtl/pcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the predictive corrector symbolizer.
// No dependencies; every other file imports this package.
package pcs_pkg;

  localparam int VAL_W     = 24;          // input value width
  localparam int RANGE_W   = VAL_W + 1;   // wrap range, up to two to the 24th
  localparam int SYM_W     = 25;          // output symbol width
  localparam int CORR_W    = VAL_W + 3;   // signed corrector before and after wrap
  localparam int PREC_W    = 5;
  localparam int BITS_W    = 4;           // small and low bit counts
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RANGE_W;
  localparam int RESULT_N  = 3;
  localparam int RES_IDX_W = 2;

  localparam int MAX_PRECISION_DEF = 24;

  localparam logic [PREC_W-1:0]  PRECISION_RESET = 5'd16;
  localparam logic [PREC_W-1:0]  LOW_SPLIT_PREC  = 5'd15;  // first precision with low bits
  localparam logic [PREC_W-1:0]  LOW_BIAS        = 5'd12;

  localparam logic [CFG_IDX_W-1:0] CFG_PRECISION      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_OVERRIDE = 1'd1;

  localparam logic [1:0] MODEL_SMALL   = 2'd0;
  localparam logic [1:0] MODEL_HIGH    = 2'd1;
  localparam logic [1:0] MODEL_LOW_POS = 2'd2;
  localparam logic [1:0] MODEL_LOW_NEG = 2'd3;

  localparam logic [RES_IDX_W-1:0] COUNT_ONE   = 2'd1;
  localparam logic [RES_IDX_W-1:0] COUNT_TWO   = 2'd2;
  localparam logic [RES_IDX_W-1:0] COUNT_THREE = 2'd3;

  // Quantities derived from the configuration registers.
  typedef struct packed {
    logic                     all_small;
    logic [BITS_W-1:0]        lbits;
    logic signed [CORR_W-1:0] range;
    logic signed [CORR_W-1:0] cmin;
    logic signed [CORR_W-1:0] cmax;
    logic signed [CORR_W-1:0] cutoff;
    logic signed [CORR_W-1:0] neg_cutoff;
    logic signed [CORR_W-1:0] hmin;
    logic signed [CORR_W-1:0] hoff;
    logic [SYM_W-1:0]         low_mask;
  } setup_t;

  // Small-model bit count for a clamped precision.
  function automatic logic [BITS_W-1:0] small_bits(input logic [PREC_W-1:0] p);
    logic [BITS_W-1:0] b;
    case (p)
      5'd0, 5'd1: b = 4'd1;
      5'd2:       b = 4'd2;
      5'd3:       b = 4'd3;
      5'd4:       b = 4'd4;
      5'd5:       b = 4'd5;
      5'd6:       b = 4'd6;
      5'd7:       b = 4'd4;
      5'd8, 5'd9, 5'd10: b = 4'd5;
      5'd11:      b = 4'd6;
      5'd12, 5'd13: b = 4'd7;
      5'd14, 5'd15: b = 4'd8;
      5'd16, 5'd17: b = 4'd9;
      5'd18, 5'd19: b = 4'd10;
      5'd20:      b = 4'd11;
      5'd21:      b = 4'd12;
      5'd22:      b = 4'd13;
      default:    b = 4'd14;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/pcs_in_if.sv]
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with the value and prediction payload.
// Depends on pcs_pkg for field widths.
interface pcs_in_if import pcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [VAL_W-1:0] real_value;
  logic [VAL_W-1:0] prediction;
  logic             sign_mode;

  modport source(output valid, op, real_value, prediction, sign_mode, input ready);
  modport sink(input valid, op, real_value, prediction, sign_mode, output ready);
endinterface

[hw/rtl/pcs_out_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one tagged model symbol.
// Depends on pcs_pkg for field widths.
interface pcs_out_if import pcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       model_id;
  logic [SYM_W-1:0] symbol;
  logic             last_of_run;

  modport source(output valid, model_id, symbol, last_of_run, input ready);
  modport sink(input valid, model_id, symbol, last_of_run, output ready);
endinterface

[hw/rtl/pcs_setup.sv]
`timescale 1ns / 1ps
// Configuration registers and the registered setup derived from them.
// Depends on pcs_pkg.
module pcs_setup import pcs_pkg::*; #(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output setup_t                setup
);

  localparam logic [RANGE_W-1:0] RANGE_LIM = RANGE_W'(1) << MAX_PRECISION;
  localparam logic [PREC_W-1:0]  PREC_MAX  = PREC_W'(MAX_PRECISION);

  logic [PREC_W-1:0]  precision;
  logic [RANGE_W-1:0] range_override;

  logic [PREC_W-1:0]        pc;
  logic [BITS_W-1:0]        sbits;
  logic [RANGE_W-1:0]       rng;
  logic                     all_small;
  logic signed [CORR_W-1:0] range_s;
  logic signed [CORR_W-1:0] half_s;
  logic signed [CORR_W-1:0] cmin;
  logic signed [CORR_W-1:0] cutoff;
  setup_t                   setup_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision      <= PRECISION_RESET;
      range_override <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRECISION:      precision      <= cfg_data[PREC_W-1:0];
        CFG_RANGE_OVERRIDE: range_override <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (precision == '0)          pc = PREC_W'(1);
    else if (precision > PREC_MAX) pc = PREC_MAX;
    else                           pc = precision;

    sbits = small_bits(pc);

    if (range_override == '0)          rng = RANGE_W'(1) << pc;
    else if (range_override > RANGE_LIM) rng = RANGE_LIM;
    else                                 rng = range_override;

    range_s   = $signed({2'b00, rng});
    half_s    = $signed({3'b000, rng[RANGE_W-1:1]});
    cmin      = -half_s;
    all_small = rng <= (RANGE_W'(1) << sbits);
    cutoff    = all_small ? half_s + CORR_W'(1)
                          : $signed(CORR_W'(1) << (sbits - BITS_W'(1)));

    setup_next.all_small  = all_small;
    setup_next.lbits      = (pc >= LOW_SPLIT_PREC) ? BITS_W'(pc - LOW_BIAS) : '0;
    setup_next.range      = range_s;
    setup_next.cmin       = cmin;
    setup_next.cmax       = cmin + range_s - CORR_W'(1);
    setup_next.cutoff     = cutoff;
    setup_next.neg_cutoff = -cutoff;
    setup_next.hmin       = cmin >>> setup_next.lbits;
    setup_next.hoff       = cmin + (cutoff <<< 1) - CORR_W'(1);
    setup_next.low_mask   = (SYM_W'(1) << setup_next.lbits) - SYM_W'(1);
  end

  // Derived setup, registered; user changes it only while idle, not enforced.
  always_ff @(posedge clk) begin
    setup <= setup_next;
  end

endmodule

[hw/rtl/predictive_corrector_symbolizer.sv]
`timescale 1ns / 1ps
// Top level of the predictive corrector symbolizer: input stage, wrap and symbol logic,
// and the result buffer. Depends on pcs_pkg, pcs_in_if, pcs_out_if and pcs_setup.

// An item is taken every cycle as long as the result side keeps up. Each item yields one,
// two or three symbols, and all of them leave through the single result buffer, one per
// cycle while the output is ready: one symbol for small correctors, two or three for
// escaped ones. An item passes the input stage register and then the result buffer before
// its first symbol appears. Configuration acts through its registers and then the setup register.
module predictive_corrector_symbolizer import pcs_pkg::*; #(
  parameter int MAX_PRECISION = MAX_PRECISION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pcs_in_if.sink                items,
  pcs_out_if.source             symbols,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  setup_t setup;

  pcs_setup #(.MAX_PRECISION(MAX_PRECISION)) u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .setup    (setup)
  );

  // Input stage.
  logic [VAL_W-1:0]         previous_value;
  logic                     s1_valid;
  logic signed [CORR_W-1:0] s1_corr;
  logic signed [CORR_W-1:0] corr_in;
  logic [VAL_W-1:0]         base;
  logic                     in_xfer;

  // Result buffer.
  logic                     buf_valid;
  logic [RES_IDX_W-1:0]     buf_count;
  logic [RES_IDX_W-1:0]     buf_idx;
  logic [1:0]               buf_model [RESULT_N];
  logic [SYM_W-1:0]         buf_symbol [RESULT_N];
  logic                     out_last;
  logic                     buf_free;

  // Symbol logic.
  logic signed [CORR_W-1:0] c_wrap;
  logic signed [CORR_W-1:0] c_sat;
  logic signed [CORR_W-1:0] high_val;
  logic                     small_hit;
  logic [RES_IDX_W-1:0]     count_next;
  logic [1:0]               model_next [RESULT_N];
  logic [SYM_W-1:0]         symbol_next [RESULT_N];

  assign out_last  = (buf_idx == buf_count - RES_IDX_W'(1));
  assign buf_free  = ~buf_valid | (symbols.ready & out_last);
  assign items.ready = ~rst & (~s1_valid | buf_free);
  assign in_xfer   = items.valid & items.ready;

  always_comb begin
    base = items.op ? previous_value : items.prediction;
    if (items.op | items.sign_mode) begin
      corr_in = $signed({3'b000, items.real_value}) - $signed({3'b000, base});
    end else begin
      corr_in = $signed({3'b000, base}) - $signed({3'b000, items.real_value});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      s1_valid       <= 1'b0;
    end else if (in_xfer) begin
      previous_value <= items.real_value;
      s1_valid       <= 1'b1;
    end else if (buf_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_corr <= corr_in;
    end
  end

  // One wrap into the interval, then saturation for correctors still outside it.
  always_comb begin
    if (s1_corr < setup.cmin)      c_wrap = s1_corr + setup.range;
    else if (s1_corr > setup.cmax) c_wrap = s1_corr - setup.range;
    else                           c_wrap = s1_corr;

    if (c_wrap < setup.cmin)      c_sat = setup.cmin;
    else if (c_wrap > setup.cmax) c_sat = setup.cmax;
    else                          c_sat = c_wrap;

    small_hit = setup.all_small | ((c_sat < setup.cutoff) & (c_sat > setup.neg_cutoff));

    if (setup.lbits == '0) begin
      high_val = c_sat[CORR_W-1] ? c_sat - setup.cmin : c_sat - setup.hoff;
    end else begin
      high_val = (c_sat >>> setup.lbits) - setup.hmin;
    end

    if (small_hit)               count_next = COUNT_ONE;
    else if (setup.lbits == '0)  count_next = COUNT_TWO;
    else                         count_next = COUNT_THREE;

    // An escape is symbol zero of the small model.
    model_next[0]  = MODEL_SMALL;
    symbol_next[0] = small_hit ? SYM_W'(c_sat + setup.cutoff) : '0;
    model_next[1]  = MODEL_HIGH;
    symbol_next[1] = SYM_W'(high_val);
    model_next[2]  = c_sat[CORR_W-1] ? MODEL_LOW_NEG : MODEL_LOW_POS;
    symbol_next[2] = SYM_W'(c_sat) & setup.low_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_count <= COUNT_ONE;
      buf_idx   <= '0;
    end else if (buf_free) begin
      buf_valid <= s1_valid;
      buf_count <= count_next;
      buf_idx   <= '0;
    end else if (symbols.ready) begin
      buf_idx <= buf_idx + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (buf_free) begin
      for (int i = 0; i < RESULT_N; i++) begin
        buf_model[i]  <= model_next[i];
        buf_symbol[i] <= symbol_next[i];
      end
    end
  end

  assign symbols.valid       = buf_valid;
  assign symbols.model_id    = buf_model[buf_idx];
  assign symbols.symbol      = buf_symbol[buf_idx];
  assign symbols.last_of_run = out_last;

  // The read position never passes the number of symbols loaded for the item.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    buf_valid |-> (buf_idx < buf_count))
    else $error("result index beyond symbol count");

  // A transfer that is not the last of an item leaves the next symbol of the same item.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (symbols.valid && symbols.ready && !symbols.last_of_run) |=>
      (buf_valid && buf_idx == $past(buf_idx) + RES_IDX_W'(1)))
    else $error("symbol run broken before its last symbol");

  // Every escaped item starts with the small-model escape symbol.
  a_escape_first: assert property (@(posedge clk) disable iff (rst)
    (buf_valid && buf_idx == '0 && buf_count != COUNT_ONE) |->
      (symbols.model_id == MODEL_SMALL && symbols.symbol == '0))
    else $error("escaped item does not start with the escape symbol");

  // An accepted item is held in the input stage on the next cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted item lost from the input stage");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for predictive_corrector_symbolizer: queued items, a symbol predictor.
// Depends on pcs_pkg, pcs_in_if and pcs_out_if from the RTL.
module tb_top;
  import pcs_pkg::*;

  localparam logic OP_GIVEN = 1'b0;  // corrector from the item's own prediction
  localparam logic OP_LAST  = 1'b1;  // corrector from the previously coded value
  localparam logic SIGN_PRED_MINUS_REAL = 1'b0;
  localparam logic SIGN_REAL_MINUS_PRED = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   PHASE_N = 12;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] real_value;
    logic [VAL_W-1:0] prediction;
    logic             sign_mode;
  } item_t;

  typedef struct packed {
    logic [1:0]       model_id;
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
  } symbol_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcs_in_if  items_bus ();
  pcs_out_if symbols_bus ();

  predictive_corrector_symbolizer dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_bus),
    .symbols   (symbols_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  item_t   item_q[$];
  symbol_t symbol_q[$];
  item_t   cur_item;
  symbol_t want;

  logic [PREC_W-1:0]     prec_reg;
  logic [CFG_DATA_W-1:0] range_reg;
  logic [VAL_W-1:0]      coded_value;   // value the block predicts from on OP_LAST
  logic [VAL_W-1:0]      tail_value;    // last value handed to the driver queue
  logic                  calm;
  int                    errors = 0;
  int                    quiet = 0;

  int unsigned prec_set [PHASE_N] = '{24, 1, 7, 14, 15, 20, 12, 0, 31, 10, 18, 16};
  int unsigned range_set [PHASE_N] = '{0, 0, 0, 0, 0, 100000, 16777216, 1, 33554431, 2,
                                       12345, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void add_symbol(input logic [1:0] model, input longint sym,
                                     input logic last);
    symbol_t s;
    s.model_id    = model;
    s.symbol      = sym[SYM_W-1:0];
    s.last_of_run = last;
    symbol_q.push_back(s);
  endfunction

  // Works out the symbols that one accepted item must produce.
  function automatic void predict_symbols(input item_t it);
    int unsigned p;
    int unsigned sb;
    int unsigned lb;
    longint rng;
    longint cmin;
    longint cmax;
    longint cut;
    longint rv;
    longint pv;
    longint corr;
    p = prec_reg;
    if (p < 1) p = 1;
    if (p > MAX_PRECISION_DEF) p = MAX_PRECISION_DEF;
    case (p)
      1, 2, 3, 4, 5, 6: sb = p;
      7:                sb = 4;
      8, 9, 10:         sb = 5;
      11:               sb = 6;
      12, 13:           sb = 7;
      14, 15:           sb = 8;
      16, 17:           sb = 9;
      18, 19:           sb = 10;
      20:               sb = 11;
      21:               sb = 12;
      22:               sb = 13;
      default:          sb = 14;
    endcase
    lb = (p >= 15) ? p - 12 : 0;
    rng = (range_reg != 0) ? longint'(range_reg) : (64'sd1 <<< p);
    if (rng > (64'sd1 <<< MAX_PRECISION_DEF)) rng = 64'sd1 <<< MAX_PRECISION_DEF;
    cmin = -(rng / 2);
    cmax = cmin + rng - 1;

    rv = it.real_value;
    pv = it.prediction;
    if (it.op == OP_LAST) begin
      pv = coded_value;
      corr = rv - pv;
    end else if (it.sign_mode == SIGN_REAL_MINUS_PRED) begin
      corr = rv - pv;
    end else begin
      corr = pv - rv;
    end
    coded_value = it.real_value;

    // One wrap, then saturation for correctors that were more than a full range outside the interval.
    if (corr < cmin) corr += rng;
    else if (corr > cmax) corr -= rng;
    if (corr < cmin) corr = cmin;
    if (corr > cmax) corr = cmax;

    if (rng <= (64'sd1 <<< sb)) begin
      add_symbol(MODEL_SMALL, corr + 1 + rng / 2, 1'b1);
      return;
    end
    cut = 64'sd1 <<< (sb - 1);
    if (((corr < 0) ? -corr : corr) < cut) begin
      add_symbol(MODEL_SMALL, corr + cut, 1'b1);
      return;
    end
    add_symbol(MODEL_SMALL, 0, 1'b0);
    if (lb == 0) begin
      if (corr < 0) add_symbol(MODEL_HIGH, corr - cmin, 1'b1);
      else add_symbol(MODEL_HIGH, corr - cmin - (2 * cut - 1), 1'b1);
    end else begin
      add_symbol(MODEL_HIGH, (corr >>> lb) - (cmin >>> lb), 1'b0);
      add_symbol((corr < 0) ? MODEL_LOW_NEG : MODEL_LOW_POS,
                 corr & ((64'sd1 <<< lb) - 1), 1'b1);
    end
  endfunction

  // Input driver: holds an item until its transfer, idles at random between items unless calm.
  always @(posedge clk) begin
    if (rst) begin
      items_bus.valid <= 1'b0;
    end else begin
      if (items_bus.valid && items_bus.ready) begin
        predict_symbols(cur_item);
      end
      if (!items_bus.valid || items_bus.ready) begin
        if (item_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
          cur_item = item_q.pop_front();
          items_bus.valid      <= 1'b1;
          items_bus.op         <= cur_item.op;
          items_bus.real_value <= cur_item.real_value;
          items_bus.prediction <= cur_item.prediction;
          items_bus.sign_mode  <= cur_item.sign_mode;
        end else begin
          items_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest expected symbol.
  always @(posedge clk) begin
    if (rst) begin
      symbols_bus.ready <= 1'b0;
    end else begin
      if (symbols_bus.valid && symbols_bus.ready) begin
        if (symbol_q.size() == 0) begin
          $error("symbol with nothing expected: model_id %0d symbol %0d last_of_run %0b",
                 symbols_bus.model_id, symbols_bus.symbol, symbols_bus.last_of_run);
          errors++;
        end else begin
          want = symbol_q.pop_front();
          if (symbols_bus.model_id !== want.model_id) begin
            $error("model_id: expected %0d, got %0d", want.model_id, symbols_bus.model_id);
            errors++;
          end
          if (symbols_bus.symbol !== want.symbol) begin
            $error("symbol: expected %0d, got %0d", want.symbol, symbols_bus.symbol);
            errors++;
          end
          if (symbols_bus.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   symbols_bus.last_of_run);
            errors++;
          end
        end
      end
      symbols_bus.ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (items_bus.valid && items_bus.ready) ||
        (symbols_bus.valid && symbols_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_item(input logic op, input logic [VAL_W-1:0] real_value,
                           input logic [VAL_W-1:0] prediction, input logic sign_mode);
    item_t it;
    it.op         = op;
    it.real_value = real_value;
    it.prediction = prediction;
    it.sign_mode  = sign_mode;
    tail_value    = real_value;
    item_q.push_back(it);
  endtask

  // Offsets of random bit width, so every magnitude band of the corrector is reached.
  task automatic queue_random_items(input int n);
    int unsigned w;
    logic [VAL_W-1:0] delta;
    logic [VAL_W-1:0] rv;
    logic op;
    repeat (n) begin
      w = $urandom_range(VAL_W);
      delta = VAL_W'($urandom & ((32'd1 << w) - 1));
      if ($urandom_range(1)) delta = -delta;
      op = 1'($urandom_range(1));
      if (op == OP_GIVEN) begin
        rv = VAL_W'($urandom);
        push_item(op, rv, rv + delta, 1'($urandom_range(1)));
      end else begin
        rv = ($urandom_range(9) < 3) ? VAL_W'($urandom) : tail_value + delta;
        push_item(op, rv, VAL_W'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || items_bus.valid || symbol_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRECISION) prec_reg = data[PREC_W-1:0];
    else range_reg = data;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_PRECISION;
    cfg_data = '0;
    prec_reg = PRECISION_RESET;
    range_reg = '0;
    coded_value = '0;
    tail_value = '0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: range 65536, small cutoff 256, four low bits.
    push_item(OP_LAST, 24'd300, 24'hFFFFFF, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd0, 24'd0, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd1000, 24'd745, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd1000, 24'd744, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd1000, 24'd744, SIGN_PRED_MINUS_REAL);
    push_item(OP_GIVEN, 24'd1000, 24'd745, SIGN_PRED_MINUS_REAL);
    push_item(OP_GIVEN, 24'd0, 24'd273, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd32767, 24'd0, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd0, 24'd32768, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd32768, 24'd0, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd0, 24'd32769, SIGN_REAL_MINUS_PRED);
    push_item(OP_GIVEN, 24'd0, 24'hFFFFFF, SIGN_PRED_MINUS_REAL);
    push_item(OP_GIVEN, 24'd0, 24'hFFFFFF, SIGN_REAL_MINUS_PRED);
    push_item(OP_LAST, 24'hFFFFFF, 24'd0, SIGN_PRED_MINUS_REAL);
    push_item(OP_LAST, 24'd0, 24'hFFFFFF, SIGN_REAL_MINUS_PRED);
    push_item(OP_LAST, 24'd17, 24'd0, SIGN_PRED_MINUS_REAL);
    push_item(OP_GIVEN, 24'd123456, 24'd123456, SIGN_PRED_MINUS_REAL);

    // Each setting starts only after every symbol of the previous one has come out.
    for (int i = 0; i < PHASE_N; i++) begin
      wait_drained();
      calm = (i == PHASE_N - 1);
      write_reg(CFG_PRECISION, CFG_DATA_W'(prec_set[i]));
      write_reg(CFG_RANGE_OVERRIDE, CFG_DATA_W'(range_set[i]));
      queue_random_items(calm ? 40 : 30);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_in_if.sv
hw/rtl/pcs_out_if.sv
hw/rtl/pcs_setup.sv
hw/rtl/predictive_corrector_symbolizer.sv
bench/tb_top.sv
